[hdl/dqp_pkg.sv]
// Shared types, register indexes and helpers for the dq power meter.
// No dependencies; used by every module of the block.
package dqp_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_POWER_SCALE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_IN     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_FB     = 2'd2;

  localparam logic [31:0] PowerScaleRst = 32'h0001_0000;

  typedef logic signed [15:0] samp_t;
  typedef logic signed [31:0] pwr_t;
  typedef logic signed [33:0] dot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT,
    ST_SCALE,
    ST_LPF,
    ST_OUT
  } state_e;

  // clamp a 37-bit signed value to 32 bits
  function automatic pwr_t sat_pwr(input logic signed [36:0] v);
    pwr_t r;
    if ((&v[36:31]) || !(|v[36:31])) begin
      r = v[31:0];
    end else if (v[36]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

[hdl/dq_power_with_lowpass_unit.sv]
// Top level of the dq power meter with lowpass: config registers, sequencer,
// history and output register. Depends on dqp_pkg, dqp_dot, dqp_scale, dqp_lpf.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one dq sample per beat:
//   volt_d, volt_q, curr_d, curr_q, signed Q1.15. Output channel
//   (out_valid_o/out_ready_i) returns one beat per sample: raw and filtered
//   active and reactive power, signed Q25.7; the filtered values are saturated.
//   Config port: cfg_we_i with cfg_idx_i (0 power_scale, 1 k1, 2 k2) and
//   cfg_data_i; writes land the same cycle. Writing k1 or k2 clears the filter
//   history. Other indexes are ignored. Write only while the block is idle.
//   An input beat passes through the bit-serial dot products, the power_scale
//   multiply (one scale bit a cycle) and the lowpass (one coefficient bit a
//   cycle), with handoffs between them, before output valid.
//   No new sample is taken while one is in process; in_ready_o is high only
//   between samples, and a new sample is taken while the last result still waits.
//   If the receiver stalls, the finished sample waits in the last step until
//   the output register frees up.
//   Reset: power_scale = 1.0, k1 = k2 = 0, history cleared, output empty.
module dq_power_with_lowpass_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dqp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  dqp_pkg::samp_t               volt_d_i,
  input  dqp_pkg::samp_t               volt_q_i,
  input  dqp_pkg::samp_t               curr_d_i,
  input  dqp_pkg::samp_t               curr_q_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output dqp_pkg::pwr_t                active_power_o,
  output dqp_pkg::pwr_t                reactive_power_o,
  output dqp_pkg::pwr_t                avg_active_power_o,
  output dqp_pkg::pwr_t                avg_reactive_power_o
);

  dqp_pkg::state_e state_q, state_d;

  logic [31:0]    power_scale_q;
  dqp_pkg::samp_t k1_q, k2_q;
  dqp_pkg::pwr_t  prev_p_q, prev_q_q, prev_pa_q, prev_qa_q;
  dqp_pkg::pwr_t  out_p_q, out_q_q, out_pa_q, out_qa_q;
  logic           out_valid_q;

  logic           dot_start, scale_start, lpf_start, load_out;
  logic           dot_done, scale_done, lpf_done, hist_clr;
  dqp_pkg::dot_t  sum_p, sum_q;
  dqp_pkg::pwr_t  pwr_p, pwr_q, avg_p, avg_q;

  dqp_dot u_dot (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (dot_start),
    .volt_d_i (volt_d_i),
    .volt_q_i (volt_q_i),
    .curr_d_i (curr_d_i),
    .curr_q_i (curr_q_i),
    .done_o   (dot_done),
    .sum_p_o  (sum_p),
    .sum_q_o  (sum_q)
  );

  dqp_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (scale_start),
    .sum_p_i       (sum_p),
    .sum_q_i       (sum_q),
    .power_scale_i (power_scale_q),
    .done_o        (scale_done),
    .pwr_p_o       (pwr_p),
    .pwr_q_o       (pwr_q)
  );

  dqp_lpf u_lpf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lpf_start),
    .x_p_i   (pwr_p),
    .x_q_i   (pwr_q),
    .xp_p_i  (prev_p_q),
    .xp_q_i  (prev_q_q),
    .yp_p_i  (prev_pa_q),
    .yp_q_i  (prev_qa_q),
    .k1_i    (k1_q),
    .k2_i    (k2_q),
    .done_o  (lpf_done),
    .y_p_o   (avg_p),
    .y_q_o   (avg_q)
  );

  assign in_ready_o = (state_q == dqp_pkg::ST_IDLE);
  assign hist_clr   = cfg_we_i &&
                      (cfg_idx_i == dqp_pkg::REG_GAIN_IN || cfg_idx_i == dqp_pkg::REG_GAIN_FB);

  always_comb begin
    state_d     = state_q;
    dot_start   = 1'b0;
    scale_start = 1'b0;
    lpf_start   = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      dqp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          dot_start = 1'b1;
          state_d   = dqp_pkg::ST_DOT;
        end
      end
      dqp_pkg::ST_DOT: begin
        if (dot_done) begin
          scale_start = 1'b1;
          state_d     = dqp_pkg::ST_SCALE;
        end
      end
      dqp_pkg::ST_SCALE: begin
        if (scale_done) begin
          lpf_start = 1'b1;
          state_d   = dqp_pkg::ST_LPF;
        end
      end
      dqp_pkg::ST_LPF: begin
        if (lpf_done) begin
          state_d = dqp_pkg::ST_OUT;
        end
      end
      dqp_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = dqp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dqp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dqp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_scale_q <= dqp_pkg::PowerScaleRst;
      k1_q          <= '0;
      k2_q          <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dqp_pkg::REG_POWER_SCALE: power_scale_q <= cfg_data_i;
        dqp_pkg::REG_GAIN_IN:     k1_q          <= cfg_data_i[15:0];
        dqp_pkg::REG_GAIN_FB:     k2_q          <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_p_q  <= '0;
      prev_q_q  <= '0;
      prev_pa_q <= '0;
      prev_qa_q <= '0;
    end else if (hist_clr) begin
      prev_p_q  <= '0;
      prev_q_q  <= '0;
      prev_pa_q <= '0;
      prev_qa_q <= '0;
    end else if (load_out) begin
      prev_p_q  <= pwr_p;
      prev_q_q  <= pwr_q;
      prev_pa_q <= avg_p;
      prev_qa_q <= avg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_p_q  <= pwr_p;
      out_q_q  <= pwr_q;
      out_pa_q <= avg_p;
      out_qa_q <= avg_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign active_power_o       = out_p_q;
  assign reactive_power_o     = out_q_q;
  assign avg_active_power_o   = out_pa_q;
  assign avg_reactive_power_o = out_qa_q;

endmodule

[hdl/dqp_dot.sv]
// Bit-serial dot products: vd*id + vq*iq and vd*iq - vq*id, one current bit a cycle.
// Depends on dqp_pkg.
module dqp_dot (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  dqp_pkg::samp_t volt_d_i,
  input  dqp_pkg::samp_t volt_q_i,
  input  dqp_pkg::samp_t curr_d_i,
  input  dqp_pkg::samp_t curr_q_i,
  output logic          done_o,
  output dqp_pkg::dot_t  sum_p_o,
  output dqp_pkg::dot_t  sum_q_o
);

  logic signed [15:0] vd_q, vq_q;
  logic [15:0]        id_q, iq_q;
  logic signed [17:0] accp_q, accq_q;
  logic [15:0]        lowp_q, lowq_q;
  logic [3:0]         cnt_q;
  logic               busy_q, done_q, last;
  logic signed [17:0] vd_x, vq_x, pp_p, pp_q;
  logic signed [18:0] sum_p, sum_q;

  assign last = &cnt_q;
  assign vd_x = {{2{vd_q[15]}}, vd_q};
  assign vq_x = {{2{vq_q[15]}}, vq_q};

  always_comb begin
    pp_p = (id_q[0] ? vd_x : 18'sd0) + (iq_q[0] ? vq_x : 18'sd0);
    pp_q = (iq_q[0] ? vd_x : 18'sd0) - (id_q[0] ? vq_x : 18'sd0);
    // sign bit of the current carries negative weight
    if (last) begin
      sum_p = {accp_q[17], accp_q} - {pp_p[17], pp_p};
      sum_q = {accq_q[17], accq_q} - {pp_q[17], pp_q};
    end else begin
      sum_p = {accp_q[17], accp_q} + {pp_p[17], pp_p};
      sum_q = {accq_q[17], accq_q} + {pp_q[17], pp_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      vd_q   <= volt_d_i;
      vq_q   <= volt_q_i;
      id_q   <= curr_d_i;
      iq_q   <= curr_q_i;
      accp_q <= '0;
      accq_q <= '0;
      lowp_q <= '0;
      lowq_q <= '0;
    end else if (busy_q) begin
      id_q   <= {1'b0, id_q[15:1]};
      iq_q   <= {1'b0, iq_q[15:1]};
      accp_q <= sum_p[18:1];
      accq_q <= sum_q[18:1];
      lowp_q <= {sum_p[0], lowp_q[15:1]};
      lowq_q <= {sum_q[0], lowq_q[15:1]};
    end
  end

  assign done_o  = done_q;
  assign sum_p_o = {accp_q, lowp_q};
  assign sum_q_o = {accq_q, lowq_q};

endmodule

[hdl/dqp_scale.sv]
// Bit-serial scaling of both dot products by 3 * power_scale, rounded to Q25.7.
// Depends on dqp_pkg.
module dqp_scale (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  dqp_pkg::dot_t  sum_p_i,
  input  dqp_pkg::dot_t  sum_q_i,
  input  logic [31:0]   power_scale_i,
  output logic          done_o,
  output dqp_pkg::pwr_t  pwr_p_o,
  output dqp_pkg::pwr_t  pwr_q_o
);

  logic signed [34:0] mp_q, mq_q;
  logic [31:0]        ps_q;
  logic signed [35:0] accp_q, accq_q;
  logic [4:0]         cnt_q;
  logic               busy_q, done_q, last;
  logic signed [34:0] pp_p, pp_q;
  logic signed [36:0] sum_p, sum_q;
  logic [30:0]        rnd_p, rnd_q;

  assign last  = &cnt_q;
  assign pp_p  = ps_q[0] ? mp_q : 35'sd0;
  assign pp_q  = ps_q[0] ? mq_q : 35'sd0;
  assign sum_p = {accp_q[35], accp_q} + {{2{pp_p[34]}}, pp_p};
  assign sum_q = {accq_q[35], accq_q} + {{2{pp_q[34]}}, pp_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // only product bits 67:38 matter, so the low half is dropped as it shifts out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mp_q   <= {sum_p_i[33], sum_p_i} + {sum_p_i, 1'b0};
      mq_q   <= {sum_q_i[33], sum_q_i} + {sum_q_i, 1'b0};
      ps_q   <= power_scale_i;
      accp_q <= '0;
      accq_q <= '0;
    end else if (busy_q) begin
      ps_q   <= {1'b0, ps_q[31:1]};
      accp_q <= sum_p[36:1];
      accq_q <= sum_q[36:1];
    end
  end

  assign rnd_p   = {accp_q[35], accp_q[35:6]} + 31'd1;
  assign rnd_q   = {accq_q[35], accq_q[35:6]} + 31'd1;
  assign pwr_p_o = {{2{rnd_p[30]}}, rnd_p[30:1]};
  assign pwr_q_o = {{2{rnd_q[30]}}, rnd_q[30:1]};
  assign done_o  = done_q;

endmodule

[hdl/dqp_lpf.sv]
// Bit-serial first-order lowpass for both powers: k1*(x+x_prev) - k2*y_prev.
// Depends on dqp_pkg (types and saturation).
module dqp_lpf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  dqp_pkg::pwr_t  x_p_i,
  input  dqp_pkg::pwr_t  x_q_i,
  input  dqp_pkg::pwr_t  xp_p_i,
  input  dqp_pkg::pwr_t  xp_q_i,
  input  dqp_pkg::pwr_t  yp_p_i,
  input  dqp_pkg::pwr_t  yp_q_i,
  input  dqp_pkg::samp_t k1_i,
  input  dqp_pkg::samp_t k2_i,
  output logic           done_o,
  output dqp_pkg::pwr_t  y_p_o,
  output dqp_pkg::pwr_t  y_q_o
);

  logic signed [32:0] sp_q, sq_q;
  logic signed [31:0] ypp_q, ypq_q;
  logic [15:0]        k1_q, k2_q;
  logic signed [34:0] accp_q, accq_q;
  logic [1:0]         lowp_q, lowq_q;
  logic [3:0]         cnt_q;
  logic               busy_q, done_q, last;
  logic signed [33:0] pp_p, pp_q;
  logic signed [35:0] sum_p, sum_q;
  logic [37:0]        rnd_p, rnd_q;

  assign last = &cnt_q;

  always_comb begin
    pp_p = (k1_q[0] ? {sp_q[32], sp_q} : 34'sd0)
         - (k2_q[0] ? {{2{ypp_q[31]}}, ypp_q} : 34'sd0);
    pp_q = (k1_q[0] ? {sq_q[32], sq_q} : 34'sd0)
         - (k2_q[0] ? {{2{ypq_q[31]}}, ypq_q} : 34'sd0);
    if (last) begin
      sum_p = {accp_q[34], accp_q} - {{2{pp_p[33]}}, pp_p};
      sum_q = {accq_q[34], accq_q} - {{2{pp_q[33]}}, pp_q};
    end else begin
      sum_p = {accp_q[34], accp_q} + {{2{pp_p[33]}}, pp_p};
      sum_q = {accq_q[34], accq_q} + {{2{pp_q[33]}}, pp_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // product bits below 14 never reach the rounded result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sp_q   <= {x_p_i[31], x_p_i} + {xp_p_i[31], xp_p_i};
      sq_q   <= {x_q_i[31], x_q_i} + {xp_q_i[31], xp_q_i};
      ypp_q  <= yp_p_i;
      ypq_q  <= yp_q_i;
      k1_q   <= k1_i;
      k2_q   <= k2_i;
      accp_q <= '0;
      accq_q <= '0;
      lowp_q <= '0;
      lowq_q <= '0;
    end else if (busy_q) begin
      k1_q   <= {1'b0, k1_q[15:1]};
      k2_q   <= {1'b0, k2_q[15:1]};
      accp_q <= sum_p[35:1];
      accq_q <= sum_q[35:1];
      lowp_q <= {sum_p[0], lowp_q[1]};
      lowq_q <= {sum_q[0], lowq_q[1]};
    end
  end

  assign rnd_p  = {accp_q[34], accp_q, lowp_q} + 38'd1;
  assign rnd_q  = {accq_q[34], accq_q, lowq_q} + 38'd1;
  assign y_p_o  = dqp_pkg::sat_pwr(rnd_p[37:1]);
  assign y_q_o  = dqp_pkg::sat_pwr(rnd_q[37:1]);
  assign done_o = done_q;

endmodule

[hdl/dqp_checker.sv]
// Port-level checks for dq_power_with_lowpass_unit, attached by bind.
// Depends on dqp_pkg for field types.
module dqp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input dqp_pkg::pwr_t active_power_o,
  input dqp_pkg::pwr_t reactive_power_o,
  input dqp_pkg::pwr_t avg_active_power_o,
  input dqp_pkg::pwr_t avg_reactive_power_o
);

  // one sample in flight: no new beat right after an accepted one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a beat");

  // a result cannot show up at the edge that accepts its sample
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared with no processing time");

  // finishing a sample frees the input side at once
  a_ready_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("input not ready after result was produced");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(active_power_o) &&
      $stable(reactive_power_o) && $stable(avg_active_power_o) &&
      $stable(avg_reactive_power_o))
    else $error("stalled output beat changed");

endmodule

bind dq_power_with_lowpass_unit dqp_checker u_dqp_checker (.*);
